FILE: sv/sha512_hash_engine_core_defines.svh
// Assertion macros shared by the hash engine RTL.
// Each macro expects clk and rst to be visible at the point of use.
`ifndef SHA512_HASH_ENGINE_CORE_DEFINES_SVH
`define SHA512_HASH_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication.
`define SHE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SHE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/sha512e_pkg.sv
// ----------------------------------------------------------------------------
// sha512e_pkg
// Types, round constants and helper functions for the SHA-512 engine.
// ----------------------------------------------------------------------------
package sha512e_pkg;

  typedef logic [63:0] word_t;
  typedef word_t vars_t [8];

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_UPDATE,
    ST_PAD,
    ST_FILL,
    ST_OUTRD,
    ST_OUTWR
  } state_t;

  // Hash memory control from the sequencer
  typedef struct packed {
    logic       rd_en;
    logic [2:0] rd_addr;
    logic       wr_en;
    logic [2:0] wr_addr;
    word_t      wr_data;
    logic       clear;
  } hmem_ctrl_t;

  localparam word_t PAD_TOP = 64'h8000_0000_0000_0000;

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

  function automatic word_t init_hash(input logic [2:0] idx);
    case (idx)
      3'd0:    init_hash = 64'h6a09e667f3bcc908;
      3'd1:    init_hash = 64'hbb67ae8584caa73b;
      3'd2:    init_hash = 64'h3c6ef372fe94f82b;
      3'd3:    init_hash = 64'ha54ff53a5f1d36f1;
      3'd4:    init_hash = 64'h510e527fade682d1;
      3'd5:    init_hash = 64'h9b05688c2b3e6c1f;
      3'd6:    init_hash = 64'h1f83d9abfb41bd6b;
      default: init_hash = 64'h5be0cd19137e2179;
    endcase
  endfunction

  // Keep the valid bytes from the top, place the pad byte after them
  function automatic word_t make_pad(input word_t w, input logic [3:0] cnt);
    word_t r;
    r = '0;
    for (int j = 0; j < 8; j++) begin
      if (4'(j) < cnt) begin
        r[63 - 8*j -: 8] = w[63 - 8*j -: 8];
      end else if (4'(j) == cnt) begin
        r[63 - 8*j -: 8] = 8'h80;
      end
    end
    make_pad = r;
  endfunction

  function automatic word_t round_k(input logic [6:0] r);
    case (r)
      7'd0:  round_k = 64'h428a2f98d728ae22;  7'd1:  round_k = 64'h7137449123ef65cd;
      7'd2:  round_k = 64'hb5c0fbcfec4d3b2f;  7'd3:  round_k = 64'he9b5dba58189dbbc;
      7'd4:  round_k = 64'h3956c25bf348b538;  7'd5:  round_k = 64'h59f111f1b605d019;
      7'd6:  round_k = 64'h923f82a4af194f9b;  7'd7:  round_k = 64'hab1c5ed5da6d8118;
      7'd8:  round_k = 64'hd807aa98a3030242;  7'd9:  round_k = 64'h12835b0145706fbe;
      7'd10: round_k = 64'h243185be4ee4b28c;  7'd11: round_k = 64'h550c7dc3d5ffb4e2;
      7'd12: round_k = 64'h72be5d74f27b896f;  7'd13: round_k = 64'h80deb1fe3b1696b1;
      7'd14: round_k = 64'h9bdc06a725c71235;  7'd15: round_k = 64'hc19bf174cf692694;
      7'd16: round_k = 64'he49b69c19ef14ad2;  7'd17: round_k = 64'hefbe4786384f25e3;
      7'd18: round_k = 64'h0fc19dc68b8cd5b5;  7'd19: round_k = 64'h240ca1cc77ac9c65;
      7'd20: round_k = 64'h2de92c6f592b0275;  7'd21: round_k = 64'h4a7484aa6ea6e483;
      7'd22: round_k = 64'h5cb0a9dcbd41fbd4;  7'd23: round_k = 64'h76f988da831153b5;
      7'd24: round_k = 64'h983e5152ee66dfab;  7'd25: round_k = 64'ha831c66d2db43210;
      7'd26: round_k = 64'hb00327c898fb213f;  7'd27: round_k = 64'hbf597fc7beef0ee4;
      7'd28: round_k = 64'hc6e00bf33da88fc2;  7'd29: round_k = 64'hd5a79147930aa725;
      7'd30: round_k = 64'h06ca6351e003826f;  7'd31: round_k = 64'h142929670a0e6e70;
      7'd32: round_k = 64'h27b70a8546d22ffc;  7'd33: round_k = 64'h2e1b21385c26c926;
      7'd34: round_k = 64'h4d2c6dfc5ac42aed;  7'd35: round_k = 64'h53380d139d95b3df;
      7'd36: round_k = 64'h650a73548baf63de;  7'd37: round_k = 64'h766a0abb3c77b2a8;
      7'd38: round_k = 64'h81c2c92e47edaee6;  7'd39: round_k = 64'h92722c851482353b;
      7'd40: round_k = 64'ha2bfe8a14cf10364;  7'd41: round_k = 64'ha81a664bbc423001;
      7'd42: round_k = 64'hc24b8b70d0f89791;  7'd43: round_k = 64'hc76c51a30654be30;
      7'd44: round_k = 64'hd192e819d6ef5218;  7'd45: round_k = 64'hd69906245565a910;
      7'd46: round_k = 64'hf40e35855771202a;  7'd47: round_k = 64'h106aa07032bbd1b8;
      7'd48: round_k = 64'h19a4c116b8d2d0c8;  7'd49: round_k = 64'h1e376c085141ab53;
      7'd50: round_k = 64'h2748774cdf8eeb99;  7'd51: round_k = 64'h34b0bcb5e19b48a8;
      7'd52: round_k = 64'h391c0cb3c5c95a63;  7'd53: round_k = 64'h4ed8aa4ae3418acb;
      7'd54: round_k = 64'h5b9cca4f7763e373;  7'd55: round_k = 64'h682e6ff3d6b2b8a3;
      7'd56: round_k = 64'h748f82ee5defb2fc;  7'd57: round_k = 64'h78a5636f43172f60;
      7'd58: round_k = 64'h84c87814a1f0ab72;  7'd59: round_k = 64'h8cc702081a6439ec;
      7'd60: round_k = 64'h90befffa23631e28;  7'd61: round_k = 64'ha4506cebde82bde9;
      7'd62: round_k = 64'hbef9a3f7b2c67915;  7'd63: round_k = 64'hc67178f2e372532b;
      7'd64: round_k = 64'hca273eceea26619c;  7'd65: round_k = 64'hd186b8c721c0c207;
      7'd66: round_k = 64'heada7dd6cde0eb1e;  7'd67: round_k = 64'hf57d4f7fee6ed178;
      7'd68: round_k = 64'h06f067aa72176fba;  7'd69: round_k = 64'h0a637dc5a2c898a6;
      7'd70: round_k = 64'h113f9804bef90dae;  7'd71: round_k = 64'h1b710b35131c471b;
      7'd72: round_k = 64'h28db77f523047d84;  7'd73: round_k = 64'h32caab7b40c72493;
      7'd74: round_k = 64'h3c9ebe0a15c9bebc;  7'd75: round_k = 64'h431d67c49c100d4c;
      7'd76: round_k = 64'h4cc5d4becb3e42b6;  7'd77: round_k = 64'h597f299cfc657e2a;
      7'd78: round_k = 64'h5fcb6fab3ad6faec;  7'd79: round_k = 64'h6c44198c4a475817;
      default: round_k = '0;
    endcase
  endfunction

endpackage

FILE: sv/sha512e_hmem.sv
// ----------------------------------------------------------------------------
// sha512e_hmem
// Eight-entry hash state memory, one read and one write port, registered
// read. Entries not written since the last clear read as the initial hash.
// ----------------------------------------------------------------------------
module sha512e_hmem (
  input  logic                    clk,
  input  logic                    rst,
  input  sha512e_pkg::hmem_ctrl_t ctl,
  output sha512e_pkg::word_t      rd_data
);
  import sha512e_pkg::*;

  word_t      mem [8];
  logic [7:0] vld;
  word_t      rd_raw;
  logic       rd_vld;
  logic [2:0] rd_addr_q;

  // Write and read the array
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_raw    <= mem[ctl.rd_addr];
      rd_addr_q <= ctl.rd_addr;
    end
  end

  // Track written entries; drop them all on clear
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (ctl.rd_en) begin
        rd_vld <= vld[ctl.rd_addr];
      end
      if (ctl.wr_en) begin
        vld[ctl.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_vld ? rd_raw : init_hash(rd_addr_q);

endmodule

FILE: sv/sha512e_round.sv
// ----------------------------------------------------------------------------
// sha512e_round
// One compression round and one message schedule expansion step.
// ----------------------------------------------------------------------------
module sha512e_round (
  input  sha512e_pkg::vars_t v,
  input  sha512e_pkg::word_t w0,
  input  sha512e_pkg::word_t w1,
  input  sha512e_pkg::word_t w9,
  input  sha512e_pkg::word_t w14,
  input  sha512e_pkg::word_t kc,
  output sha512e_pkg::vars_t v_next,
  output sha512e_pkg::word_t w_next
);
  import sha512e_pkg::*;

  word_t big_s1, big_s0, ch, maj, t1, t2, sm0, sm1;

  // Round function
  always_comb begin
    big_s1 = rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41);
    ch     = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1     = v[7] + big_s1 + ch + kc + w0;
    big_s0 = rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39);
    maj    = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2     = big_s0 + maj;
    v_next[0] = t1 + t2;
    v_next[1] = v[0];
    v_next[2] = v[1];
    v_next[3] = v[2];
    v_next[4] = v[3] + t1;
    v_next[5] = v[4];
    v_next[6] = v[5];
    v_next[7] = v[6];
  end

  // Schedule word sixteen places ahead
  always_comb begin
    sm1    = rotr(w14, 19) ^ rotr(w14, 61) ^ (w14 >> 6);
    sm0    = rotr(w1, 1) ^ rotr(w1, 8) ^ (w1 >> 7);
    w_next = w0 + sm1 + w9 + sm0;
  end

endmodule

FILE: sv/sha512_hash_engine_core.sv
// ----------------------------------------------------------------------------
// sha512_hash_engine_core
// SHA-512 over a stream of 64-bit message words, digest out word by word.
// Processing: after its 16 words are accepted, a block takes hash reads,
// 80 rounds and write-backs, and no new word is taken meanwhile; the single
// shared round unit sets this pace. The first digest word follows the last
// word once the padding is done (one or two more blocks, each after its zero
// fill); the digest then leaves word by word, held while digest_ready is low.
// Reset: control cleared, hash memory reads the initial hash through
// per-entry valid bits, no clearing pass.
// ----------------------------------------------------------------------------
`include "sha512_hash_engine_core_defines.svh"

module sha512_hash_engine_core #(
  parameter int DIGEST_WORDS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [63:0] msg_word,
  input  logic [3:0]  byte_count,
  input  logic        last_word,
  input  logic        msg_valid,
  output logic        msg_ready,
  output logic [63:0] digest_word,
  output logic [2:0]  word_number,
  output logic        final_word,
  output logic        digest_valid,
  input  logic        digest_ready
);
  import sha512e_pkg::*;

  state_t     state, state_next;
  logic [3:0] cnt;
  logic [6:0] rnd;
  logic [2:0] dig_idx;
  logic [3:0] wf;
  logic [63:0] total;
  logic       tail, pad_pending, len_ok;
  word_t      w [16];
  vars_t      v, v_rnd;
  word_t      w_new, pad_word, inj, hrd;
  logic [3:0] cnt_sat;
  logic       accept, dig_last;
  hmem_ctrl_t hctl;

  assign msg_ready = (state == ST_IDLE);
  assign accept    = msg_valid && msg_ready;
  assign cnt_sat   = (byte_count > 4'd8) ? 4'd8 : byte_count;
  assign dig_last  = (dig_idx == 3'(DIGEST_WORDS - 1));

  // Word fed in while padding: pad, zero fill, or bit length
  always_comb begin
    if (state == ST_PAD) begin
      inj = pad_word;
    end else if (len_ok && wf == 4'd14) begin
      inj = {61'd0, total[63:61]};
    end else if (len_ok && wf == 4'd15) begin
      inj = {total[60:0], 3'd0};
    end else begin
      inj = '0;
    end
  end

  sha512e_hmem u_hmem (
    .clk     (clk),
    .rst     (rst),
    .ctl     (hctl),
    .rd_data (hrd)
  );

  sha512e_round u_round (
    .v      (v),
    .w0     (w[0]),
    .w1     (w[1]),
    .w9     (w[9]),
    .w14    (w[14]),
    .kc     (round_k(rnd)),
    .v_next (v_rnd),
    .w_next (w_new)
  );

  // Sequencer: next state and memory control
  always_comb begin
    state_next = state;
    hctl       = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if ((!last_word || cnt_sat == 4'd8) && wf == 4'd15) begin
            state_next = ST_LOAD;
          end else if (last_word) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_LOAD: begin
        hctl.rd_en   = (cnt < 4'd8);
        hctl.rd_addr = cnt[2:0];
        if (cnt == 4'd8) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd == 7'd79) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        hctl.rd_en   = (cnt < 4'd8);
        hctl.rd_addr = cnt[2:0];
        if (cnt != 4'd0) begin
          hctl.wr_en   = 1'b1;
          hctl.wr_addr = 3'(cnt - 4'd1);
          hctl.wr_data = hrd + v[0];
        end
        if (cnt == 4'd8) begin
          if (!tail) begin
            state_next = ST_IDLE;
          end else if (pad_pending) begin
            state_next = ST_PAD;
          end else if (len_ok) begin
            state_next = ST_OUTRD;
          end else begin
            state_next = ST_FILL;
          end
        end
      end
      ST_PAD, ST_FILL: begin
        state_next = (wf == 4'd15) ? ST_LOAD : ST_FILL;
      end
      ST_OUTRD: begin
        hctl.rd_en   = 1'b1;
        hctl.rd_addr = dig_idx;
        if (!digest_valid || digest_ready) begin
          state_next = ST_OUTWR;
        end
      end
      ST_OUTWR: begin
        if (dig_last) begin
          hctl.clear = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_OUTRD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control counters and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      rnd          <= '0;
      wf           <= '0;
      total        <= '0;
      tail         <= 1'b0;
      pad_pending  <= 1'b0;
      len_ok       <= 1'b0;
      dig_idx      <= '0;
      digest_valid <= 1'b0;
    end else begin
      if (digest_valid && digest_ready) begin
        digest_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (accept) begin
            if (!last_word) begin
              total <= total + 64'd8;
              wf    <= wf + 4'd1;
            end else begin
              total       <= total + 64'(cnt_sat);
              tail        <= 1'b1;
              pad_pending <= 1'b1;
              len_ok      <= 1'b0;
              if (cnt_sat == 4'd8) begin
                wf <= wf + 4'd1;
              end
            end
          end
        end
        ST_LOAD: begin
          cnt <= (cnt == 4'd8) ? 4'd0 : cnt + 4'd1;
          rnd <= '0;
        end
        ST_ROUND: begin
          rnd <= rnd + 7'd1;
        end
        ST_UPDATE: begin
          cnt <= (cnt == 4'd8) ? 4'd0 : cnt + 4'd1;
          if (cnt == 4'd8 && tail && !pad_pending && !len_ok) begin
            len_ok <= 1'b1;
          end
        end
        ST_PAD: begin
          wf          <= wf + 4'd1;
          pad_pending <= 1'b0;
          len_ok      <= (wf <= 4'd13);
        end
        ST_FILL: begin
          wf <= wf + 4'd1;
        end
        ST_OUTWR: begin
          digest_valid <= 1'b1;
          if (dig_last) begin
            dig_idx <= '0;
            tail    <= 1'b0;
            total   <= '0;
            wf      <= '0;
            len_ok  <= 1'b0;
          end else begin
            dig_idx <= dig_idx + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Schedule window, working variables and result payload
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept && (!last_word || cnt_sat == 4'd8)) begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= msg_word;
        end
        if (accept && last_word) begin
          pad_word <= (cnt_sat == 4'd8) ? PAD_TOP : make_pad(msg_word, cnt_sat);
        end
      end
      ST_LOAD: begin
        if (cnt != 4'd0) begin
          for (int i = 0; i < 7; i++) v[i] <= v[i+1];
          v[7] <= hrd;
        end
      end
      ST_ROUND: begin
        v <= v_rnd;
        for (int i = 0; i < 15; i++) w[i] <= w[i+1];
        w[15] <= w_new;
      end
      ST_UPDATE: begin
        if (cnt != 4'd0) begin
          for (int i = 0; i < 7; i++) v[i] <= v[i+1];
          v[7] <= v[0];
        end
      end
      ST_PAD, ST_FILL: begin
        for (int i = 0; i < 15; i++) w[i] <= w[i+1];
        w[15] <= inj;
      end
      ST_OUTWR: begin
        digest_word <= hrd;
        word_number <= dig_idx;
        final_word  <= dig_last;
      end
      default: ;
    endcase
  end

  `SHE_ASSERT_IMP(a_round_range, state == ST_ROUND, rnd < 7'd80, "round index past 79")
  `SHE_ASSERT_NXT(a_last_blocks, msg_valid && msg_ready && last_word, !msg_ready,
                  "input taken again right after the last word")
  `SHE_ASSERT_NXT(a_result_held, digest_valid && !digest_ready,
                  digest_valid && $stable(digest_word) && $stable(word_number),
                  "pending result changed")

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SHA-512 engine: a table of directed requests
// (empty and full-word tails, overflowing counts, padding that spills into an
// extra block, known digests), then random messages of many lengths under
// varying input gaps and output stalls, all checked by a local SHA-512 model.
// ----------------------------------------------------------------------------
module tb_top;
  import sha512e_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [63:0] word;
    logic [3:0]  cnt;
    logic        last;
    logic [63:0] h0;   // expected first digest word, or zero if predicted only
  } req_row_t;

  typedef struct {
    logic [63:0] word;
    logic [2:0]  num;
    logic        fin;
  } digest_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [63:0] msg_word = '0;
  logic [3:0]  byte_count = '0;
  logic        last_word = 1'b0;
  logic        msg_valid = 1'b0;
  logic        msg_ready;
  logic [63:0] digest_word;
  logic [2:0]  word_number;
  logic        final_word;
  logic        digest_valid;
  logic        digest_ready = 1'b0;

  sha512_hash_engine_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  logic [63:0] hstate [8];
  logic [63:0] blk [16];
  logic [63:0] total_bytes;
  int          filled;
  digest_t     pending_digests [$];

  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int idle_cycles = 0;
  int n_msgs = 0, n_digests = 0;
  bit done = 1'b0;

  function automatic logic [63:0] rr(logic [63:0] x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] k_const(int i);
    logic [63:0] kt [80] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
    return kt[i];
  endfunction

  function automatic logic [63:0] iv(int i);
    logic [63:0] t [8] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
    return t[i];
  endfunction

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) hstate[i] = iv(i);
    total_bytes = '0;
    filled = 0;
  endtask

  // Compress the held block into the running hash
  task automatic compress();
    logic [63:0] w [16];
    logic [63:0] v [8];
    logic [63:0] x, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 0; i < 8; i++) v[i] = hstate[i];
    for (int r = 0; r < 80; r++) begin
      if (r >= 16) begin
        s1 = rr(w[(r-2)%16], 19) ^ rr(w[(r-2)%16], 61) ^ (w[(r-2)%16] >> 6);
        s0 = rr(w[(r-15)%16], 1) ^ rr(w[(r-15)%16], 8) ^ (w[(r-15)%16] >> 7);
        w[r%16] = w[r%16] + s1 + w[(r-7)%16] + s0;
      end
      x = w[r%16];
      t1 = v[7] + (rr(v[4], 14) ^ rr(v[4], 18) ^ rr(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_const(r) + x;
      t2 = (rr(v[0], 28) ^ rr(v[0], 34) ^ rr(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hstate[i] = hstate[i] + v[i];
  endtask

  task automatic store_word(logic [63:0] w);
    blk[filled] = w;
    filled++;
    if (filled == 16) begin
      compress();
      filled = 0;
    end
  endtask

  // Advance the hash by one accepted request; on the tail queue the digest
  task automatic hash_request(logic [63:0] w, logic [3:0] cnt, logic last);
    int n;
    logic [63:0] tail;
    digest_t d;
    if (!last) begin
      total_bytes += 8;
      store_word(w);
      return;
    end
    n = (cnt > 8) ? 8 : int'(cnt);
    total_bytes += n;
    if (n == 8) begin
      store_word(w);
      tail = 64'h80 << 56;
    end else begin
      tail = '0;
      for (int j = 0; j < n; j++) tail[63-8*j -: 8] = w[63-8*j -: 8];
      tail[63-8*n -: 8] = 8'h80;
    end
    blk[filled] = tail;
    filled++;
    if (filled > 14) begin
      while (filled < 16) begin
        blk[filled] = '0;
        filled++;
      end
      compress();
      filled = 0;
    end
    while (filled < 14) begin
      blk[filled] = '0;
      filled++;
    end
    blk[14] = total_bytes >> 61;
    blk[15] = total_bytes << 3;
    compress();
    for (int k = 0; k < 8; k++) begin
      d.word = hstate[k];
      d.num = 3'(k);
      d.fin = (k == 7);
      pending_digests.push_back(d);
    end
    restart_hash();
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Offer one request and hold it until accepted; drop valid only on idle cycles
  task automatic send(logic [63:0] w, logic [3:0] cnt, logic last);
    while (($urandom_range(99) < send_idle_pct)) begin
      msg_valid <= 1'b0;
      @(posedge clk);
    end
    msg_word <= w;
    byte_count <= cnt;
    last_word <= last;
    msg_valid <= 1'b1;
    do @(posedge clk); while (!msg_ready);
    hash_request(w, cnt, last);
    if (last) n_msgs++;
  endtask

  task automatic send_message(int words);
    for (int i = 0; i < words - 1; i++)
      send({$urandom, $urandom}, 4'($urandom_range(15)), 1'b0);
    send({$urandom, $urandom}, 4'($urandom_range(15)), 1'b1);
  endtask

  task automatic drain();
    msg_valid <= 1'b0;
    while (pending_digests.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stall unless a hold-off is in force
  always @(posedge clk) begin
    if (rst) begin
      digest_ready <= 1'b0;
    end else begin
      digest_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check accepted digest words
  always @(posedge clk) begin
    digest_t e;
    if (!rst && digest_valid && digest_ready) begin
      n_digests++;
      if (pending_digests.size() == 0) begin
        report_mismatch("unexpected digest", digest_word, '0);
      end else begin
        e = pending_digests.pop_front();
        if (digest_word !== e.word) report_mismatch("digest_word", digest_word, e.word);
        if (word_number !== e.num) report_mismatch("word_number", word_number, e.num);
        if (final_word !== e.fin) report_mismatch("final_word", final_word, e.fin);
      end
    end
  end

  // Watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (msg_valid && msg_ready) || (digest_valid && digest_ready) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired");
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Long receiver hold-off, counted here
  task automatic hold_receiver(int cycles);
    hold_off = 1'b1;
    repeat (cycles) @(posedge clk);
    hold_off = 1'b0;
  endtask

  req_row_t rows [] = '{
    // empty message: tail word with no bytes
    '{64'h0, 4'd0, 1'b1, 64'hcf83e1357eefb8bd},
    // "abc"
    '{64'h6162630000000000, 4'd3, 1'b1, 64'hddaf35a193617aba},
    // all-ones full tail word, oversized count, stray count before the end
    '{64'hffffffffffffffff, 4'd8, 1'b1, 64'h0},
    '{64'hffffffffffffffff, 4'd15, 1'b0, 64'h0},
    '{64'h0123456789abcdef, 4'd9, 1'b1, 64'h0},
    // unused bytes set so they must be cleared
    '{64'h00ffffffffffffff, 4'd1, 1'b1, 64'h0},
    '{64'h12345678deadbeef, 4'd7, 1'b1, 64'h0},
    // fourteen words then a full tail: pad spills into an extra block
    '{64'haaaaaaaaaaaaaaaa, 4'd0, 1'b0, 64'h0}
  };

  initial begin
    int target;
    restart_hash();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows; known first digest words checked directly as well
    foreach (rows[i]) begin
      send(rows[i].word, rows[i].cnt, rows[i].last);
      if (rows[i].h0 != 0) begin
        if (pending_digests.size() < 8 || pending_digests[pending_digests.size()-8].word
            !== rows[i].h0)
          report_mismatch("known digest", pending_digests[0].word, rows[i].h0);
      end
    end
    for (int i = 0; i < 13; i++) send({$urandom, $urandom}, 4'd8, 1'b0);
    send(64'h8000000000000001, 4'd8, 1'b1);
    for (int i = 0; i < 15; i++) send(64'h5555555555555555, 4'd4, 1'b0);
    send(64'hfedcba9876543210, 4'd0, 1'b1);
    drain();

    // Random messages over the idling phases, a few per phase
    target = 4;
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = (p == 1 || p == 3) ? ((p == 1) ? 47 : 28) : 0;
      recv_stall_pct = (p == 2) ? 47 : ((p == 3) ? 28 : 0);
      if (p == 0) fork hold_receiver(3000); join_none
      repeat (target) begin
        case ($urandom_range(3))
          0: send_message($urandom_range(1, 3));
          1: send_message($urandom_range(14, 17));
          2: send_message($urandom_range(30, 34));
          default: send_message($urandom_range(4, 13));
        endcase
      end
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (300) @(posedge clk);
    done = 1'b1;
    $display("covered %0d messages, %0d digest words checked, tails of 0..15 bytes",
             n_msgs, n_digests);
    $display("phases: free-running, input gaps, output stalls, both, long hold-off");
    if (errors == 0 && pending_digests.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: sha512_hash_engine_core.f
+incdir+sv
sv/sha512e_pkg.sv
sv/sha512e_hmem.sv
sv/sha512e_round.sv
sv/sha512_hash_engine_core.sv
tb/tb_top.sv
